/* src/gbm_pkg.sv */
// ----------------------------------------------------------------------------
// gbm_pkg
// Shared types, constants and helper function of the grid-bucket track matcher.
// ----------------------------------------------------------------------------
package gbm_pkg;

  localparam int MODULES_DEF      = 4;
  localparam int CELLS_X_DEF      = 7;
  localparam int CELLS_Z_DEF      = 6;
  localparam int BUCKET_DEPTH_DEF = 8;

  // Half widths of the module plane in 1/64 cm
  localparam int HALF_X = 4672;
  localparam int HALF_Z = 4032;
  // Squared distance limit, (9999 cm^2) * 64 * 64
  localparam logic [31:0] DIST_LIMIT = 32'd40955904;

  // Action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_MIN_ENERGY = 2'd0;
  localparam logic [1:0] REG_MIN_TIME   = 2'd1;
  localparam logic [1:0] REG_MAX_TIME   = 2'd2;

  localparam logic [15:0] MIN_ENERGY_RST = 16'd307;
  localparam logic [15:0] MIN_TIME_RST   = 16'hFF06;
  localparam logic [15:0] MAX_TIME_RST   = 16'd250;

  // Stored slot: x, z, momentum, electron, charge (46 bits)
  typedef struct packed {
    logic signed [13:0] x;
    logic signed [13:0] z;
    logic [15:0]        mom;
    logic               el;
    logic               pos;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Electron selection on fixed cuts
  function automatic logic is_electron(input logic [15:0] p,
                                       input logic signed [11:0] se,
                                       input logic signed [11:0] spi,
                                       input logic signed [11:0] ska,
                                       input logic signed [11:0] spr);
    logic e;
    e = (se > -12'sd48) && (se < 12'sd80);
    if (p > 16'd1024 && p < 16'd3072 && spi < 12'sd32) e = 1'b0;
    if (p < 16'd512 && spi > -12'sd16 && spi < 12'sd16) e = 1'b0;
    if (p < 16'd1536 && ska > -12'sd16 && ska < 12'sd16) e = 1'b0;
    if (p < 16'd2048 && spr > -12'sd16 && spr < 12'sd16) e = 1'b0;
    return e;
  endfunction

endpackage

/* src/gbm_if.sv */
// ----------------------------------------------------------------------------
// gbm_in_if / gbm_out_if
// Valid/ready channels carrying request and result transactions.
// ----------------------------------------------------------------------------
interface gbm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [2:0]         module_req;
  logic signed [13:0] pos_x;
  logic signed [13:0] pos_z;
  logic [15:0]        momentum;
  logic               positive;
  logic signed [11:0] sigma_electron;
  logic signed [11:0] sigma_pion;
  logic signed [11:0] sigma_kaon;
  logic signed [11:0] sigma_proton;
  logic [15:0]        cluster_energy;
  logic signed [15:0] cluster_time;
  modport source (output valid, action, module_req, pos_x, pos_z, momentum, positive,
                  sigma_electron, sigma_pion, sigma_kaon, sigma_proton,
                  cluster_energy, cluster_time, input ready);
  modport sink (input valid, action, module_req, pos_x, pos_z, momentum, positive,
                sigma_electron, sigma_pion, sigma_kaon, sigma_proton,
                cluster_energy, cluster_time, output ready);
endinterface

interface gbm_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [14:0] delta_x;
  logic signed [14:0] delta_z;
  logic [15:0]        match_momentum;
  logic               match_electron;
  logic               match_positive;
  logic               bucket_overflow;
  modport source (output valid, found, delta_x, delta_z, match_momentum, match_electron,
                  match_positive, bucket_overflow, input ready);
  modport sink (input valid, found, delta_x, delta_z, match_momentum, match_electron,
                match_positive, bucket_overflow, output ready);
endinterface

/* src/gbm_ram.sv */
// ----------------------------------------------------------------------------
// gbm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module gbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* src/gbm_cell.sv */
// ----------------------------------------------------------------------------
// gbm_cell
// Cell index and neighbour flags of a position, from constant cell edges.
// ----------------------------------------------------------------------------
module gbm_cell #(
  parameter int CELLS = 7,
  parameter int HALF  = 4672
) (
  input  logic signed [13:0]           p,
  output logic [$clog2(CELLS+1)-1:0]   idx,
  output logic                         lo_nb,
  output logic                         hi_nb
);

  localparam int  IW  = $clog2(CELLS+1);
  localparam logic signed [31:0] CS = 32'(CELLS);
  localparam logic signed [31:0] TH = 32'(2*HALF - CELLS*HALF);

  logic signed [31:0] off;
  logic signed [31:0] num;
  logic signed [31:0] cp;

  // Count the cell edges at or below the scaled offset; this clamps to the grid
  always_comb begin
    off = 32'(p) + 32'(HALF);
    num = off * CS;
    cp  = 32'(p) * CS;
    idx = '0;
    for (int k = 1; k < CELLS; k++) begin
      if (num >= 32'(2 * HALF * k)) idx = IW'(k);
    end
    lo_nb = cp > TH;
    hi_nb = cp < -TH;
  end

endmodule

/* src/grid_bucket_nearest_track_match_top.sv */
// ----------------------------------------------------------------------------
// grid_bucket_nearest_track_match_top
// Grid-bucket nearest-track matcher: bucket store, clear, insert and cluster query.
// ----------------------------------------------------------------------------
//  channel | dir | handshake      | carries
//  req     | in  | valid/ready    | action, module, position, track, cluster
//  res     | out | valid/ready    | match result and overflow flag
//  apb     | in  | psel/penable   | min_energy, min_time, max_time
//
//  Clear completes at the accept; insert runs accept, count read, slot write.
//  Query: after the accept, each of the nine search steps has one select
//  state; a searched cell adds a count read and, with n entries, n slot reads
//  and a last compare, one slot at a time on the single slot read port; a final
//  select and the result state close it.
//  Reset (rst, synchronous) empties all buckets at once via count valid bits.
//  A result waits in the output register; further requests are taken, and only
//  the next query result holds in its last step until the register is free.
// ----------------------------------------------------------------------------
module grid_bucket_nearest_track_match_top #(
  parameter int MODULES      = gbm_pkg::MODULES_DEF,
  parameter int CELLS_X      = gbm_pkg::CELLS_X_DEF,
  parameter int CELLS_Z      = gbm_pkg::CELLS_Z_DEF,
  parameter int BUCKET_DEPTH = gbm_pkg::BUCKET_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  gbm_in_if.sink      req,
  gbm_out_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NCELLS = MODULES * CELLS_X * CELLS_Z;
  localparam int CW     = $clog2(NCELLS);
  localparam int SD     = BUCKET_DEPTH;
  localparam int SW     = (SD > 1) ? $clog2(SD) : 1;
  localparam int NW     = $clog2(SD + 1);
  localparam int EW     = $clog2(NCELLS * SD);
  localparam int XW     = $clog2(CELLS_X + 1);
  localparam int ZW     = $clog2(CELLS_Z + 1);
  localparam int MW     = $clog2(MODULES + 1) > 3 ? $clog2(MODULES + 1) : 3;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_WR, S_Q_CELL, S_Q_CNT, S_Q_ENT, S_Q_LAST, S_Q_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [15:0] min_energy, min_time, max_time;
  logic [1:0]  reg_idx;
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_energy <= gbm_pkg::MIN_ENERGY_RST;
      min_time   <= gbm_pkg::MIN_TIME_RST;
      max_time   <= gbm_pkg::MAX_TIME_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        gbm_pkg::REG_MIN_ENERGY: min_energy <= pwdata[15:0];
        gbm_pkg::REG_MIN_TIME:   min_time   <= pwdata[15:0];
        gbm_pkg::REG_MAX_TIME:   max_time   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gbm_pkg::REG_MIN_ENERGY: prdata = {16'd0, min_energy};
      gbm_pkg::REG_MIN_TIME:   prdata = {{16{min_time[15]}}, min_time};
      gbm_pkg::REG_MAX_TIME:   prdata = {{16{max_time[15]}}, max_time};
      default:                 prdata = '0;
    endcase
  end

  // Cell of the incoming request
  logic [XW-1:0] ix;
  logic [ZW-1:0] iz;
  logic lft, rgt, low, upp;
  gbm_cell #(.CELLS(CELLS_X), .HALF(gbm_pkg::HALF_X)) u_cx (
    .p(req.pos_x), .idx(ix), .lo_nb(lft), .hi_nb(rgt));
  gbm_cell #(.CELLS(CELLS_Z), .HALF(gbm_pkg::HALF_Z)) u_cz (
    .p(req.pos_z), .idx(iz), .lo_nb(low), .hi_nb(upp));

  logic mod_ok;
  logic [CW-1:0] cell_in;
  assign mod_ok  = (req.module_req >= 3'd1) && (MW'(req.module_req) <= MW'(MODULES));
  assign cell_in = CW'((32'(req.module_req) - 32'd1) * 32'(CELLS_X * CELLS_Z)
                       + 32'(ix) * 32'(CELLS_Z) + 32'(iz));

  // Count store with valid bits, and slot memory
  logic [NCELLS-1:0] cnt_vld;
  logic              cnt_we;
  logic [CW-1:0]     cnt_waddr, cnt_raddr;
  logic [NW-1:0]     cnt_wdata, cnt_rraw, cnt_rd;
  logic [CW-1:0]     cnt_rcell;
  logic              ent_we;
  logic [EW-1:0]     ent_waddr, ent_raddr;
  gbm_pkg::slot_t    ent_wdata, ent_rd;
  logic [gbm_pkg::SLOT_W-1:0] ent_rraw;

  gbm_ram #(.WIDTH(NW), .DEPTH(NCELLS)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rraw));
  gbm_ram #(.WIDTH(gbm_pkg::SLOT_W), .DEPTH(NCELLS * SD)) u_ent (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rraw));
  assign ent_rd = gbm_pkg::slot_t'(ent_rraw);
  assign cnt_rd = cnt_vld[cnt_rcell] ? cnt_rraw : '0;

  // Request holding registers
  gbm_pkg::slot_t    cur;
  logic [CW-1:0]     cur_cell;
  logic [8:0]        nb_mask;
  logic [3:0]        nb_k;
  logic [SW-1:0]     ent_j;
  logic [NW-1:0]     ent_n;
  logic [31:0]       best;
  logic              have;
  gbm_pkg::slot_t    mslot;
  logic signed [14:0] bx, bz;
  logic              overflow;

  // Neighbour cell for search step k
  logic signed [CW+1:0] nb_cell;
  always_comb begin
    case (nb_k)
      4'd0: nb_cell = $signed({2'b0, cur_cell});
      4'd1: nb_cell = $signed({2'b0, cur_cell}) - (CW+2)'(CELLS_Z + 1);
      4'd2: nb_cell = $signed({2'b0, cur_cell}) - (CW+2)'(CELLS_Z);
      4'd3: nb_cell = $signed({2'b0, cur_cell}) - (CW+2)'(CELLS_Z - 1);
      4'd4: nb_cell = $signed({2'b0, cur_cell}) - (CW+2)'(1);
      4'd5: nb_cell = $signed({2'b0, cur_cell}) + (CW+2)'(1);
      4'd6: nb_cell = $signed({2'b0, cur_cell}) + (CW+2)'(CELLS_Z - 1);
      4'd7: nb_cell = $signed({2'b0, cur_cell}) + (CW+2)'(CELLS_Z);
      4'd8: nb_cell = $signed({2'b0, cur_cell}) + (CW+2)'(CELLS_Z + 1);
      default: nb_cell = '0;
    endcase
  end
  logic nb_in;
  assign nb_in = (nb_cell >= 0) && (nb_cell < (CW+2)'(NCELLS));

  // Distance of the slot just read
  logic signed [14:0] dx, dz;
  logic [31:0]        sq_dist;
  assign dx      = 15'(ent_rd.x) - 15'(cur.x);
  assign dz      = 15'(ent_rd.z) - 15'(cur.z);
  assign sq_dist = 32'($unsigned(30'(dx * dx))) + 32'($unsigned(30'(dz * dz)));

  logic gate_ok;
  assign gate_ok = (req.cluster_energy >= min_energy)
                && ($signed(req.cluster_time) >= $signed(min_time))
                && ($signed(req.cluster_time) <= $signed(max_time));

  assign req.ready = (state == S_IDLE);

  // Memory addressing
  always_comb begin
    cnt_raddr = (state == S_IDLE) ? cell_in : cur_cell;
    ent_raddr = EW'(32'(cnt_rcell) * 32'(SD) + 32'(ent_j));
    if (state == S_Q_CELL) cnt_raddr = CW'(nb_cell);
    cnt_we    = (state == S_INS_WR) && (cnt_rd < NW'(SD));
    cnt_waddr = cur_cell;
    cnt_wdata = cnt_rd + NW'(1);
    ent_we    = cnt_we;
    ent_waddr = EW'(32'(cur_cell) * 32'(SD) + 32'(cnt_rd[SW-1:0]));
    ent_wdata = cur;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt_vld   <= '0;
      overflow  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != S_Q_DONE) res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur.x     <= req.pos_x;
            cur.z     <= req.pos_z;
            cur.mom   <= req.momentum;
            cur.pos   <= req.positive;
            cur.el    <= gbm_pkg::is_electron(req.momentum, req.sigma_electron,
                           req.sigma_pion, req.sigma_kaon, req.sigma_proton);
            cur_cell  <= cell_in;
            cnt_rcell <= cell_in;
            nb_mask   <= {rgt && upp, rgt, rgt && low, upp, low,
                          lft && upp, lft, lft && low, 1'b1};
            nb_k      <= '0;
            best      <= gbm_pkg::DIST_LIMIT;
            have      <= 1'b0;
            mslot     <= '0;
            bx        <= '0;
            bz        <= '0;
            case (req.action)
              gbm_pkg::ACT_CLEAR: begin
                cnt_vld  <= '0;
                overflow <= 1'b0;
              end
              gbm_pkg::ACT_INSERT: if (mod_ok) state <= S_INS_RD;
              gbm_pkg::ACT_QUERY:  if (mod_ok && gate_ok) state <= S_Q_CELL;
              default: ;
            endcase
          end
        end
        S_INS_RD: state <= S_INS_WR;
        S_INS_WR: begin
          if (cnt_rd >= NW'(SD)) overflow <= 1'b1;
          else cnt_vld[cur_cell] <= 1'b1;
          state <= S_IDLE;
        end
        S_Q_CELL: begin
          if (nb_k > 4'd8) begin
            state <= S_Q_DONE;
          end else if (nb_mask[nb_k] && nb_in) begin
            cnt_rcell <= CW'(nb_cell);
            state     <= S_Q_CNT;
          end else begin
            nb_k <= nb_k + 4'd1;
          end
        end
        S_Q_CNT: begin
          ent_n <= cnt_rd;
          ent_j <= '0;
          nb_k  <= nb_k + 4'd1;
          state <= (cnt_rd == '0) ? S_Q_CELL : S_Q_ENT;
        end
        S_Q_ENT: begin
          // one slot read issued per cycle, compared in the next cycle
          if (32'(ent_j) + 32'd1 >= 32'(ent_n)) state <= S_Q_LAST;
          else ent_j <= ent_j + SW'(1);
          if (ent_j != '0) begin
            if (sq_dist < best) begin
              best <= sq_dist; mslot <= ent_rd; bx <= dx; bz <= dz; have <= 1'b1;
            end
          end
        end
        S_Q_LAST: begin
          if (sq_dist < best) begin
            best <= sq_dist; mslot <= ent_rd; bx <= dx; bz <= dz; have <= 1'b1;
          end
          state <= S_Q_CELL;
        end
        S_Q_DONE: begin
          // hold until the output register is free
          if (!res.valid || res.ready) begin
            res.valid           <= 1'b1;
            res.found           <= have && (mslot.mom != '0);
            res.delta_x         <= (have && mslot.mom != '0) ? bx : '0;
            res.delta_z         <= (have && mslot.mom != '0) ? bz : '0;
            res.match_momentum  <= (have) ? mslot.mom : '0;
            res.match_electron  <= (have && mslot.mom != '0) && mslot.el;
            res.match_positive  <= (have && mslot.mom != '0) && mslot.pos;
            res.bucket_overflow <= overflow;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("request taken while busy");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> res.valid) else $error("result lost");
  a_nofound_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.found) |-> (res.match_momentum == '0))
    else $error("empty result carries momentum");

endmodule
